@@ rtl/acmac_pkg.sv @@
// package for the aes cmac stream unit
// holds payload structs, register indexes, constants and aes helper functions
// no dependencies
`default_nettype none
package acmac_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_of_message;
	} acmac_in_t;

	typedef struct packed {
		logic [63:0] mac_high;
		logic [63:0] mac_low;
	} acmac_out_t;

	localparam logic [0:0] REG_KEY_HIGH = 1'd0;
	localparam logic [0:0] REG_KEY_LOW  = 1'd1;

	localparam logic [7:0] RB_POLY  = 8'h87;
	localparam logic [7:0] PAD_MARK = 8'h80;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] tbl [256];
		tbl = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return tbl[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
		return b[127 - 8 * i -: 8];
	endfunction

	// one aes round; last round skips mixcolumns
	function automatic logic [127:0] aes_round(input logic [127:0] s,
			input logic [127:0] rk, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[4 * c + i] = sbox(blk_byte(s, 4 * ((c + i) % 4) + i));
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
				t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++)
			r[127 - 8 * i -: 8] = t[i];
		return r ^ rk;
	endfunction

	// next round key from the previous one
	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, tw;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ tw;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] dbl(input logic [127:0] x);
		return {x[126:0], 1'b0} ^ (x[127] ? {120'd0, RB_POLY} : 128'd0);
	endfunction

endpackage
`default_nettype wire

@@ rtl/aes_cmac_stream_unit.sv @@
// aes-128 cmac over a byte stream, one byte per request
// the aes rounds run one per cycle on a shared round unit; uses acmac_pkg
// a byte request passes through ST_BYTE; one that opens a new block first runs ST_CHAIN
// a last request then runs ST_LKEY for L=E(0) and ST_MAC for the final mac pass
// one request at a time; in_stall is high whenever the state is not ST_IDLE
// reset: chain, position, seen flag and key go to zero; output empties
`default_nettype none
module aes_cmac_stream_unit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire acmac_pkg::acmac_in_t    in_data,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output acmac_pkg::acmac_out_t        out_data,
	input  wire logic                    cfg_we,
	input  wire logic [0:0]              cfg_index,
	input  wire logic [63:0]             cfg_data
);
	import acmac_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHAIN = 6'b000010,
		ST_BYTE  = 6'b000100,
		ST_LKEY  = 6'b001000,
		ST_MAC   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t       state_q;
	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] chain_q, blk_q, rk_q;
	logic [3:0]   pos_q, round_q;
	logic         seen_q;
	acmac_in_t    req_q;
	logic [7:0]   rcon;
	logic [127:0] rk_nxt, rnd_nxt, pad_blk, byte_blk, kfin;
	logic         pad_need;

	always_comb begin
		case (round_q)
			4'd1: rcon = 8'h01;  4'd2: rcon = 8'h02;  4'd3: rcon = 8'h04;
			4'd4: rcon = 8'h08;  4'd5: rcon = 8'h10;  4'd6: rcon = 8'h20;
			4'd7: rcon = 8'h40;  4'd8: rcon = 8'h80;  4'd9: rcon = 8'h1b;
			4'd10: rcon = 8'h36;
			default: rcon = 8'h00;
		endcase
	end

	assign rk_nxt  = key_next(rk_q, rcon);
	assign rnd_nxt = aes_round(blk_q, rk_nxt, round_q == 4'd10);
	assign byte_blk = {120'd0, req_q.data_byte} << (8 * (15 - 32'(pos_q)));
	assign pad_blk  = {120'd0, PAD_MARK} << (8 * (15 - 32'(pos_q)));
	assign pad_need = !seen_q || pos_q != 4'd0;
	// rnd_nxt is L in the last ST_LKEY round
	assign kfin = pad_need ? dbl(dbl(rnd_nxt)) : dbl(rnd_nxt);

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = state_q == ST_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			key_high_q <= '0;
			key_low_q  <= '0;
			chain_q    <= '0;
			pos_q      <= '0;
			seen_q     <= 1'b0;
			round_q    <= '0;
			req_q      <= '0;
			blk_q      <= '0;
			rk_q       <= '0;
			out_data   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_KEY_HIGH) key_high_q <= cfg_data;
				else key_low_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						rk_q  <= {key_high_q, key_low_q};
						round_q <= 4'd1;
						if (in_data.has_byte && pos_q == 4'd0 && seen_q) begin
							blk_q   <= chain_q ^ {key_high_q, key_low_q};
							state_q <= ST_CHAIN;
						end else if (in_data.has_byte) begin
							state_q <= ST_BYTE;
						end else if (in_data.last_of_message) begin
							blk_q   <= {key_high_q, key_low_q};
							state_q <= ST_LKEY;
						end
					end
				end
				ST_CHAIN: begin
					blk_q   <= rnd_nxt;
					rk_q    <= rk_nxt;
					round_q <= round_q + 4'd1;
					if (round_q == 4'd10) begin
						chain_q <= rnd_nxt;
						state_q <= ST_BYTE;
					end
				end
				ST_BYTE: begin
					chain_q <= chain_q ^ byte_blk;
					pos_q   <= pos_q + 4'd1;
					seen_q  <= 1'b1;
					rk_q    <= {key_high_q, key_low_q};
					blk_q   <= {key_high_q, key_low_q};
					round_q <= 4'd1;
					state_q <= req_q.last_of_message ? ST_LKEY : ST_IDLE;
				end
				ST_LKEY: begin
					blk_q   <= rnd_nxt;
					rk_q    <= rk_nxt;
					round_q <= round_q + 4'd1;
					if (round_q == 4'd10) begin
						blk_q    <= kfin ^ chain_q ^ (pad_need ? pad_blk : 128'd0)
							^ {key_high_q, key_low_q};
						rk_q     <= {key_high_q, key_low_q};
						round_q  <= 4'd1;
						state_q  <= ST_MAC;
					end
				end
				ST_MAC: begin
					blk_q   <= rnd_nxt;
					rk_q    <= rk_nxt;
					round_q <= round_q + 4'd1;
					if (round_q == 4'd10) begin
						out_data <= rnd_nxt;
						chain_q  <= '0;
						pos_q    <= '0;
						seen_q   <= 1'b0;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
